// ===== rtl/core/bplt_pkg.sv =====
// Package with sizes, link-store constants and controller/datapath types for the bridge pair table.
`timescale 1ns / 1ps

package bplt_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int NODE_COUNT  = 128;

    localparam int DEPTH   = MAX_ENTRIES + 2;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int NODE_W  = $clog2(NODE_COUNT);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int STEP_W  = $clog2(MAX_ENTRIES);

    // Widths of the channel fields.
    localparam int MODE_W   = 1;
    localparam int NODE_F_W = 7;
    localparam int SLOT_F_W = 7;
    localparam int CNT_F_W  = 7;

    localparam logic [IDX_W-1:0] FREE_HEAD = IDX_W'(0);
    localparam logic [IDX_W-1:0] DATA_HEAD = IDX_W'(MAX_ENTRIES + 1);

    localparam logic MODE_ADD = 1'b0;

    typedef enum logic [1:0] {
        RS_DATA_HEAD = 2'd0,
        RS_FREE_HEAD = 2'd1,
        RS_LINK_Q    = 2'd2
    } t_rd_sel;

    typedef enum logic [2:0] {
        WS_NONE        = 3'd0,
        WS_FREE_FROM_Q = 3'd1,
        WS_FRESH_HEAD  = 3'd2,
        WS_DHEAD_FRESH = 3'd3,
        WS_PRED_NXT    = 3'd4,
        WS_FOUND_Q     = 3'd5,
        WS_FREE_FOUND  = 3'd6
    } t_wr_sel;

    typedef enum logic [1:0] {
        RK_ERR = 2'd0,
        RK_ADD = 2'd1,
        RK_REM = 2'd2
    } t_res_kind;

    typedef struct packed {
        logic      load;
        logic      walk_start;
        logic      walk_step;
        logic      step_inc;
        logic      capture_head;
        logic      capture_found;
        logic      capture_fresh;
        logic      node_wr;
        logic      cnt_inc;
        logic      cnt_dec;
        logic      res_load;
        t_res_kind res_kind;
        t_rd_sel   rd_sel;
        t_wr_sel   wr_sel;
    } t_cmd;

    typedef struct packed {
        logic eq;
        logic mode;
        logic match;
        logic q_slot;
        logic walk_end;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/core/bplt_if.sv =====
// Request and response channel interfaces of the bridge pair table.
`timescale 1ns / 1ps

interface bplt_req_if import bplt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [NODE_F_W-1:0] node_a;
    logic [NODE_F_W-1:0] node_b;

    modport source (output valid, output mode, output node_a, output node_b, input ready);
    modport sink   (input valid, input mode, input node_a, input node_b, output ready);
endinterface

interface bplt_rsp_if import bplt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                status;
    logic [SLOT_F_W-1:0] slot;
    logic [CNT_F_W-1:0]  entry_count;

    modport source (output valid, output status, output slot, output entry_count, input ready);
    modport sink   (input valid, input status, input slot, input entry_count, output ready);
endinterface

// ===== rtl/core/bplt_ctrl.sv =====
// Controller state machine that sequences the list walk, allocation and unlink steps.
`timescale 1ns / 1ps

module bplt_ctrl import bplt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_CHECK  = 12'b0000_0000_0010,
        S_WHEAD  = 12'b0000_0000_0100,
        S_WALK   = 12'b0000_0000_1000,
        S_AFRESH = 12'b0000_0001_0000,
        S_ANEXT  = 12'b0000_0010_0000,
        S_AW1    = 12'b0000_0100_0000,
        S_AW2    = 12'b0000_1000_0000,
        S_R1     = 12'b0001_0000_0000,
        S_R2     = 12'b0010_0000_0000,
        S_R3     = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } t_state;

    t_state    r_state, n_state;
    t_res_kind r_kind, n_kind;
    t_cmd      cmd;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

    always_comb begin
        n_state           = r_state;
        n_kind            = r_kind;
        cmd.load          = 1'b0;
        cmd.walk_start    = 1'b0;
        cmd.walk_step     = 1'b0;
        cmd.step_inc      = 1'b0;
        cmd.capture_head  = 1'b0;
        cmd.capture_found = 1'b0;
        cmd.capture_fresh = 1'b0;
        cmd.node_wr       = 1'b0;
        cmd.cnt_inc       = 1'b0;
        cmd.cnt_dec       = 1'b0;
        cmd.res_load      = 1'b0;
        cmd.res_kind      = r_kind;
        cmd.rd_sel        = RS_DATA_HEAD;
        cmd.wr_sel        = WS_NONE;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_kind   = RK_ERR;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.eq) begin
                    n_state = S_DONE;
                end else begin
                    cmd.walk_start = 1'b1;
                    cmd.rd_sel     = RS_DATA_HEAD;
                    n_state        = S_WHEAD;
                end
            end
            S_WHEAD: begin
                cmd.capture_head = 1'b1;
                if (i_sts.q_slot) begin
                    cmd.walk_step = 1'b1;
                    cmd.rd_sel    = RS_LINK_Q;
                    n_state       = S_WALK;
                end else if (i_sts.mode == MODE_ADD) begin
                    cmd.rd_sel = RS_FREE_HEAD;
                    n_state    = S_AFRESH;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WALK: begin
                if (i_sts.match) begin
                    cmd.capture_found = 1'b1;
                    // A match on add is a duplicate and leaves the table alone.
                    n_state = (i_sts.mode == MODE_ADD) ? S_DONE : S_R1;
                end else if (i_sts.walk_end || !i_sts.q_slot) begin
                    if (i_sts.mode == MODE_ADD) begin
                        cmd.rd_sel = RS_FREE_HEAD;
                        n_state    = S_AFRESH;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    cmd.walk_step = 1'b1;
                    cmd.step_inc  = 1'b1;
                    cmd.rd_sel    = RS_LINK_Q;
                end
            end
            S_AFRESH: begin
                if (i_sts.q_slot) begin
                    cmd.capture_fresh = 1'b1;
                    cmd.rd_sel        = RS_LINK_Q;
                    n_state           = S_ANEXT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ANEXT: begin
                cmd.wr_sel  = WS_FREE_FROM_Q;
                cmd.node_wr = 1'b1;
                n_state     = S_AW1;
            end
            S_AW1: begin
                cmd.wr_sel = WS_FRESH_HEAD;
                n_state    = S_AW2;
            end
            S_AW2: begin
                cmd.wr_sel  = WS_DHEAD_FRESH;
                cmd.cnt_inc = 1'b1;
                n_kind      = RK_ADD;
                n_state     = S_DONE;
            end
            S_R1: begin
                cmd.wr_sel = WS_PRED_NXT;
                cmd.rd_sel = RS_FREE_HEAD;
                n_state    = S_R2;
            end
            S_R2: begin
                cmd.wr_sel = WS_FOUND_Q;
                n_state    = S_R3;
            end
            S_R3: begin
                cmd.wr_sel  = WS_FREE_FOUND;
                cmd.cnt_dec = 1'b1;
                n_kind      = RK_REM;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    cmd.res_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= RK_ERR;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

endmodule

// ===== rtl/core/bplt_dp.sv =====
// Datapath with the node and link stores, walk registers, pair count and result register.
`timescale 1ns / 1ps

module bplt_dp import bplt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [NODE_F_W-1:0] i_node_a,
    input  logic [NODE_F_W-1:0] i_node_b,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic                o_status,
    output logic [SLOT_F_W-1:0] o_slot,
    output logic [CNT_F_W-1:0]  o_entry_count
);

    logic [IDX_W-1:0]  link_mem [DEPTH];
    logic [NODE_W-1:0] low_mem  [DEPTH];
    logic [NODE_W-1:0] high_mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;

    logic [IDX_W-1:0]  r_link_q;
    logic [IDX_W-1:0]  r_rst_q;
    logic              r_vld_q;
    logic [NODE_W-1:0] r_low_q;
    logic [NODE_W-1:0] r_high_q;

    logic              r_mode;
    logic              r_eq;
    logic [NODE_W-1:0] r_lo;
    logic [NODE_W-1:0] r_hi;
    logic [IDX_W-1:0]  r_cur;
    logic [IDX_W-1:0]  r_prev;
    logic [STEP_W-1:0] r_steps;
    logic [IDX_W-1:0]  r_head_link;
    logic [IDX_W-1:0]  r_found;
    logic [IDX_W-1:0]  r_pred;
    logic [IDX_W-1:0]  r_nxt;
    logic [IDX_W-1:0]  r_fresh;
    logic [CNT_W-1:0]  r_count;

    logic                r_out_valid;
    logic                r_status;
    logic [SLOT_F_W-1:0] r_slot;
    logic [CNT_F_W-1:0]  r_cnt_out;

    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [IDX_W-1:0]  link_q;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  rst_val;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  wr_data;
    logic [SLOT_F_W-1:0] res_slot;

    assign node_a = NODE_W'(i_node_a);
    assign node_b = NODE_W'(i_node_b);

    // An entry never written since reset reads as its reset link value.
    assign link_q = r_vld_q ? r_link_q : r_rst_q;

    always_comb begin
        case (i_cmd.rd_sel)
            RS_DATA_HEAD: rd_addr = DATA_HEAD;
            RS_FREE_HEAD: rd_addr = FREE_HEAD;
            RS_LINK_Q:    rd_addr = link_q;
            default:      rd_addr = DATA_HEAD;
        endcase
    end

    assign rst_val = (rd_addr < IDX_W'(MAX_ENTRIES)) ? IDX_W'(rd_addr + IDX_W'(1)) : IDX_W'(0);

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = FREE_HEAD;
        wr_data = link_q;
        case (i_cmd.wr_sel)
            WS_FREE_FROM_Q: begin
                wr_addr = FREE_HEAD;
                wr_data = link_q;
            end
            WS_FRESH_HEAD: begin
                wr_addr = r_fresh;
                wr_data = r_head_link;
            end
            WS_DHEAD_FRESH: begin
                wr_addr = DATA_HEAD;
                wr_data = r_fresh;
            end
            WS_PRED_NXT: begin
                wr_addr = r_pred;
                wr_data = r_nxt;
            end
            WS_FOUND_Q: begin
                wr_addr = r_found;
                wr_data = link_q;
            end
            WS_FREE_FOUND: begin
                wr_addr = FREE_HEAD;
                wr_data = r_found;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            link_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.node_wr) begin
            low_mem[r_fresh]  <= r_lo;
            high_mem[r_fresh] <= r_hi;
        end
        r_link_q <= link_mem[rd_addr];
        r_low_q  <= low_mem[rd_addr];
        r_high_q <= high_mem[rd_addr];
        r_rst_q  <= rst_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_q <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            r_vld_q <= r_vld[rd_addr];
        end
    end

    // Request capture and walk registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode[0];
            r_eq   <= (node_a == node_b);
            r_lo   <= (node_a < node_b) ? node_a : node_b;
            r_hi   <= (node_a < node_b) ? node_b : node_a;
        end
        if (i_cmd.walk_start) begin
            r_cur   <= DATA_HEAD;
            r_prev  <= DATA_HEAD;
            r_steps <= '0;
        end else if (i_cmd.walk_step) begin
            r_prev <= r_cur;
            r_cur  <= link_q;
            if (i_cmd.step_inc) begin
                r_steps <= r_steps + STEP_W'(1);
            end
        end
        if (i_cmd.capture_head) begin
            r_head_link <= link_q;
        end
        if (i_cmd.capture_found) begin
            r_found <= r_cur;
            r_pred  <= r_prev;
            r_nxt   <= link_q;
        end
        if (i_cmd.capture_fresh) begin
            r_fresh <= link_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.cnt_dec && (r_count != '0)) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    always_comb begin
        case (i_cmd.res_kind)
            RK_ADD:  res_slot = SLOT_F_W'(r_fresh);
            RK_REM:  res_slot = SLOT_F_W'(r_found);
            default: res_slot = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_status  <= (i_cmd.res_kind == RK_ERR);
            r_slot    <= res_slot;
            r_cnt_out <= CNT_F_W'(r_count);
        end
    end

    assign o_sts.eq       = r_eq;
    assign o_sts.mode     = r_mode;
    assign o_sts.match    = (r_low_q == r_lo) && (r_high_q == r_hi);
    assign o_sts.q_slot   = (link_q >= IDX_W'(1)) && (link_q <= IDX_W'(MAX_ENTRIES));
    assign o_sts.walk_end = (r_steps == STEP_W'(MAX_ENTRIES - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_slot        = r_slot;
    assign o_entry_count = r_cnt_out;

endmodule

// ===== rtl/core/bridge_pair_list_table_unit.sv =====
// Top level of the bridge pair table: controller and datapath joined on command and status.
// Requests are handled one at a time; the walk visits one data-list slot per cycle, and the
// next request is taken while a result waits. Reset: synchronous active low; all slots start
// on the free chain at once, so a request is accepted as soon as reset is released.
`timescale 1ns / 1ps

module bridge_pair_list_table_unit import bplt_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bplt_req_if.sink     i_req,
    bplt_rsp_if.source   o_rsp
);

    t_cmd cmd;
    t_sts sts;

    bplt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bplt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_mode        (i_req.mode),
        .i_node_a      (i_req.node_a),
        .i_node_b      (i_req.node_b),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_status      (o_rsp.status),
        .o_slot        (o_rsp.slot),
        .o_entry_count (o_rsp.entry_count)
    );

endmodule

// ===== verif/tb_bridge_pair_list_table_unit.sv =====
// Self-checking testbench for the bridge pair table: directed and random add/remove traffic.
`timescale 1ns / 1ps

module tb_bridge_pair_list_table_unit;
    import bplt_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int HOLD_OFF       = 300;
    localparam logic [7:0] EMPTY_NODE = 8'hFF;
    localparam logic MODE_REMOVE = ~MODE_ADD;

    typedef struct packed {
        logic                status;
        logic [SLOT_F_W-1:0] slot;
        logic [CNT_F_W-1:0]  entry_count;
    } bridge_result_t;

    logic i_clk;
    logic i_rst_n;

    bplt_req_if req_ch ();
    bplt_rsp_if rsp_ch ();

    bridge_pair_list_table_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the pair table.
    logic [7:0]       pair_low  [DEPTH];
    logic [7:0]       pair_high [DEPTH];
    logic [IDX_W-1:0] pair_link [DEPTH];
    int               pair_total;

    bridge_result_t expected_results [$];
    int error_count;
    int req_idle_pct;
    int rsp_idle_pct;
    int rsp_hold_cycles;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void reset_pair_table();
        for (int i = 0; i < DEPTH; i++) begin
            pair_low[i]  = EMPTY_NODE;
            pair_high[i] = EMPTY_NODE;
            pair_link[i] = (i < MAX_ENTRIES) ? IDX_W'(i + 1) : '0;
        end
        pair_total = 0;
    endfunction

    function automatic bit is_table_slot(int idx);
        return idx >= 1 && idx <= MAX_ENTRIES;
    endfunction

    // Applies one request to the shadow table and returns the response it must produce.
    function automatic bridge_result_t apply_bridge_request(logic mode, logic [NODE_F_W-1:0] a,
                                                            logic [NODE_F_W-1:0] b);
        bridge_result_t res;
        int lo;
        int hi;
        int prev;
        int cur;
        int found;
        int pred;
        int fresh;
        int steps;
        bit done;
        res.status = 1'b1;
        res.slot   = '0;
        if (a != b) begin
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            found = 0;
            pred  = DATA_HEAD;
            prev  = DATA_HEAD;
            cur   = pair_link[DATA_HEAD];
            steps = 0;
            done  = 1'b0;
            while (!done && steps < MAX_ENTRIES) begin
                if (!is_table_slot(cur)) begin
                    done = 1'b1;
                end else if (pair_low[cur] == lo && pair_high[cur] == hi) begin
                    found = cur;
                    pred  = prev;
                    done  = 1'b1;
                end else begin
                    prev = cur;
                    cur  = pair_link[cur];
                    steps++;
                end
            end
            if (mode == MODE_ADD) begin
                fresh = pair_link[FREE_HEAD];
                if (found == 0 && is_table_slot(fresh)) begin
                    pair_link[FREE_HEAD] = pair_link[fresh];
                    pair_low[fresh]      = 8'(lo);
                    pair_high[fresh]     = 8'(hi);
                    pair_link[fresh]     = pair_link[DATA_HEAD];
                    pair_link[DATA_HEAD] = IDX_W'(fresh);
                    pair_total++;
                    res.status = 1'b0;
                    res.slot   = SLOT_F_W'(fresh);
                end
            end else if (found != 0) begin
                pair_link[pred]      = pair_link[found];
                pair_low[found]      = EMPTY_NODE;
                pair_high[found]     = EMPTY_NODE;
                pair_link[found]     = pair_link[FREE_HEAD];
                pair_link[FREE_HEAD] = IDX_W'(found);
                if (pair_total > 0) pair_total--;
                res.status = 1'b0;
                res.slot   = SLOT_F_W'(found);
            end
        end
        res.entry_count = CNT_F_W'(pair_total);
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR t=%0t %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Offers one request, waits for the transaction and records its expected response.
    task automatic send_request(logic mode, logic [NODE_F_W-1:0] a, logic [NODE_F_W-1:0] b);
        while ($urandom_range(0, 99) < req_idle_pct) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_ch.valid  <= 1'b1;
        req_ch.mode   <= mode;
        req_ch.node_a <= a;
        req_ch.node_b <= b;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        expected_results.push_back(apply_bridge_request(mode, a, b));
    endtask

    // Picks a pair held in the table, in random order; returns 0 if none was hit.
    task automatic pick_held_pair(int tries, output bit hit, output logic [NODE_F_W-1:0] a,
                                  output logic [NODE_F_W-1:0] b);
        int k;
        hit = 1'b0;
        for (int t = 0; t < tries && !hit; t++) begin
            k = $urandom_range(1, MAX_ENTRIES);
            if (pair_low[k] != EMPTY_NODE) begin
                hit = 1'b1;
                if ($urandom_range(0, 1)) begin
                    a = pair_low[k][NODE_F_W-1:0];
                    b = pair_high[k][NODE_F_W-1:0];
                end else begin
                    a = pair_high[k][NODE_F_W-1:0];
                    b = pair_low[k][NODE_F_W-1:0];
                end
            end
        end
    endtask

    task automatic test_equal_nodes();
        send_request(MODE_ADD, 7'd0, 7'd0);
        send_request(MODE_ADD, 7'd127, 7'd127);
        send_request(MODE_REMOVE, 7'd45, 7'd45);
    endtask

    task automatic test_add_remove_basic();
        send_request(MODE_REMOVE, 7'd1, 7'd2);
        send_request(MODE_ADD, 7'd0, 7'd127);
        send_request(MODE_ADD, 7'd127, 7'd0);
        send_request(MODE_ADD, 7'd3, 7'd5);
        send_request(MODE_ADD, 7'd85, 7'd42);
        send_request(MODE_ADD, 7'd42, 7'd85);
        send_request(MODE_REMOVE, 7'd5, 7'd3);
        send_request(MODE_REMOVE, 7'd5, 7'd3);
        send_request(MODE_REMOVE, 7'd9, 7'd10);
        send_request(MODE_ADD, 7'd6, 7'd3);
        send_request(MODE_REMOVE, 7'd0, 7'd127);
        send_request(MODE_REMOVE, 7'd42, 7'd85);
        send_request(MODE_REMOVE, 7'd3, 7'd6);
        send_request(MODE_REMOVE, 7'd3, 7'd6);
    endtask

    // Fills every slot, probes the full table, then drains it in random order.
    task automatic test_fill_and_drain();
        logic [NODE_F_W-1:0] a;
        logic [NODE_F_W-1:0] b;
        bit hit;
        while (pair_total < MAX_ENTRIES) begin
            send_request(MODE_ADD, 7'($urandom_range(0, 125)), 7'($urandom_range(0, 125)));
        end
        // Nodes 126 and 127 never appear in the fill, so this pair is absent.
        send_request(MODE_ADD, 7'd127, 7'd126);
        send_request(MODE_REMOVE, 7'd126, 7'd127);
        pick_held_pair(1000, hit, a, b);
        send_request(MODE_ADD, a, b);
        while (pair_total > 0) begin
            pick_held_pair(1000, hit, a, b);
            if (hit) send_request(MODE_REMOVE, a, b);
        end
        send_request(MODE_REMOVE, 7'd126, 7'd127);
    endtask

    // The receiver holds off while requests keep coming, so the input must stall.
    task automatic test_backpressure();
        @(posedge i_clk);
        rsp_hold_cycles = HOLD_OFF;
        repeat (8) begin
            send_request(MODE_ADD, 7'($urandom_range(0, 15)), 7'($urandom_range(0, 15)));
        end
    endtask

    task automatic test_random_traffic(int count, int tx_pct, int rx_pct);
        logic [NODE_F_W-1:0] a;
        logic [NODE_F_W-1:0] b;
        bit hit;
        int roll;
        int add_bias;
        req_idle_pct = tx_pct;
        rsp_idle_pct = rx_pct;
        add_bias = 50;
        for (int n = 0; n < count; n++) begin
            // Shift the add/remove balance now and then so the table swings between empty and full.
            if (n % 64 == 0) add_bias = $urandom_range(25, 75);
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                a = 7'($urandom_range(0, 127));
                send_request(1'($urandom_range(0, 1)), a, a);
            end else if (roll < 20) begin
                send_request(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                             7'($urandom_range(0, 127)));
            end else if ($urandom_range(0, 99) < add_bias) begin
                send_request(MODE_ADD, 7'($urandom_range(0, 15)), 7'($urandom_range(0, 15)));
            end else begin
                pick_held_pair(8, hit, a, b);
                if (!hit) begin
                    a = 7'($urandom_range(0, 15));
                    b = 7'($urandom_range(0, 15));
                end
                send_request(MODE_REMOVE, a, b);
            end
        end
    endtask

    // Response ready, with random stalls and the long hold-off.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rsp_hold_cycles > 0) begin
                rsp_ch.ready <= 1'b0;
                rsp_hold_cycles--;
            end else begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        bridge_result_t want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("response with no pending request", rsp_ch.slot, 0);
            end else begin
                want = expected_results.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", rsp_ch.status, want.status);
                if (rsp_ch.slot !== want.slot)
                    report_mismatch("slot", rsp_ch.slot, want.slot);
                if (rsp_ch.entry_count !== want.entry_count)
                    report_mismatch("entry_count", rsp_ch.entry_count, want.entry_count);
            end
        end
    end

    // Ends the run if no transaction happens on either channel for too long.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d responses pending", expected_results.size());
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.mode     = MODE_ADD;
        req_ch.node_a   = '0;
        req_ch.node_b   = '0;
        error_count     = 0;
        quiet_cycles    = 0;
        rsp_hold_cycles = 0;
        req_idle_pct    = 25;
        rsp_idle_pct    = 55;
        reset_pair_table();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_equal_nodes();
        test_add_remove_basic();
        test_fill_and_drain();
        test_backpressure();
        test_random_traffic(330, 25, 55);
        test_random_traffic(330, 55, 25);
        test_random_traffic(330, 0, 0);

        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/bplt_pkg.sv
rtl/core/bplt_if.sv
rtl/core/bplt_ctrl.sv
rtl/core/bplt_dp.sv
rtl/core/bridge_pair_list_table_unit.sv
verif/tb_bridge_pair_list_table_unit.sv
